[rtl/owrl_pkg.sv]
// Shared types and constants for the overwrite ring event log.
package owrl_pkg;

  typedef enum logic [2:0] {
    CmdPush  = 3'd0,
    CmdPop   = 3'd1,
    CmdPeek  = 3'd2,
    CmdDrop  = 3'd3,
    CmdClear = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    StIdle,
    StExec,
    StOut
  } state_e;

  typedef struct packed {
    logic cfg_wr;
    logic load;
    logic exec;
    logic step;
  } ctl_t;

  typedef struct packed {
    logic more;
  } sts_t;

  localparam int CmdW      = 3;
  localparam int ValW      = 64;
  localparam int OffW      = 6;
  localparam int CntW      = 5;
  localparam int LevelW    = 6;
  localparam int CapW      = 7;
  localparam int CapRst    = 64;
  localparam int MinRing   = 2;

endpackage

[rtl/owrl_ctrl.sv]
// Controller state machine sequencing configuration writes, request intake, execution and result delivery.
module owrl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  owrl_pkg::sts_t sts_i,
  output owrl_pkg::ctl_t ctl_o
);
  import owrl_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (!cfg_valid_i && in_valid_i) begin
          state_d = StExec;
        end
      end
      StExec: begin
        state_d = StOut;
      end
      StOut: begin
        if (out_ready_i && !sts_i.more) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    cfg_ready_o  = (state_q == StIdle);
    in_ready_o   = (state_q == StIdle) && !cfg_valid_i;
    out_valid_o  = (state_q == StOut);
    ctl_o.cfg_wr = (state_q == StIdle) && cfg_valid_i;
    ctl_o.load   = (state_q == StIdle) && !cfg_valid_i && in_valid_i;
    ctl_o.exec   = (state_q == StExec);
    ctl_o.step   = (state_q == StOut) && out_ready_i && sts_i.more;
  end

endmodule

[rtl/owrl_dp.sv]
// Datapath: entry memory, ring pointers, peek walker and result registers.
module owrl_dp #(
  parameter int DEPTH    = 64,
  parameter int MAX_PEEK = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  owrl_pkg::ctl_t               ctl_i,
  output owrl_pkg::sts_t               sts_o,
  input  logic [owrl_pkg::CapW-1:0]    cfg_capacity_i,
  input  logic [owrl_pkg::CmdW-1:0]    cmd_i,
  input  logic [owrl_pkg::ValW-1:0]    push_value_i,
  input  logic [owrl_pkg::OffW-1:0]    peek_offset_i,
  input  logic [owrl_pkg::CntW-1:0]    peek_count_i,
  output logic                         status_o,
  output logic [owrl_pkg::ValW-1:0]    data_o,
  output logic                         last_o,
  output logic [owrl_pkg::LevelW-1:0]  level_o,
  output logic                         is_empty_o,
  output logic                         is_full_o
);
  import owrl_pkg::*;

  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW        = (AW > CapW) ? CapW : AW;
  localparam int NW        = PW + 1;
  localparam int KW        = $clog2(MAX_PEEK + 1);
  localparam int RingRstI  = (DEPTH < CapRst) ? DEPTH : CapRst;
  localparam logic [NW-1:0] RingRst = NW'(RingRstI);

  logic [ValW-1:0] mem [DEPTH];
  logic [ValW-1:0] rd_q;

  logic [CmdW-1:0] cmd_q;
  logic [ValW-1:0] val_q;
  logic [OffW-1:0] off_q;
  logic [CntW-1:0] cnt_q;

  logic [PW-1:0] rp_q, rp_d, wp_q, wp_d, pk_q, pk_d;
  logic [NW-1:0] ring_q, ring_d;
  logic [KW-1:0] rem_q, rem_d;
  logic          status_q, status_d, last_q, last_d, sel_q, sel_d;

  logic          mem_we, rd_en;
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] lv, rp_nx, wp_nx, p0;
  logic          empty, full;
  logic [7:0]    psum;
  logic [6:0]    cnt7, avail7, num7;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p,
                                              input logic [NW-1:0] n);
    logic [NW-1:0] pn;
    pn = NW'(p) + NW'(1);
    return (pn >= n) ? '0 : pn[PW-1:0];
  endfunction

  always_comb begin
    if (wp_q >= rp_q) begin
      lv = wp_q - rp_q;
    end else begin
      lv = PW'(NW'(wp_q) + ring_q - NW'(rp_q));
    end
    empty = (lv == '0);
    full  = (NW'(lv) == ring_q - NW'(1));
    rp_nx = ring_next(rp_q, ring_q);
    wp_nx = ring_next(wp_q, ring_q);

    psum = 8'(rp_q) + 8'(off_q);
    if (psum >= 8'(ring_q)) begin
      psum = psum - 8'(ring_q);
    end
    p0 = psum[PW-1:0];

    cnt7 = 7'(cnt_q);
    if (cnt7 == 7'd0) begin
      cnt7 = 7'd1;
    end else if (cnt7 > 7'(MAX_PEEK)) begin
      cnt7 = 7'(MAX_PEEK);
    end
    avail7 = 7'(lv) - 7'(off_q);
    num7   = (cnt7 < avail7) ? cnt7 : avail7;
  end

  always_comb begin
    rp_d     = rp_q;
    wp_d     = wp_q;
    pk_d     = pk_q;
    ring_d   = ring_q;
    rem_d    = rem_q;
    status_d = status_q;
    last_d   = last_q;
    sel_d    = sel_q;
    mem_we   = 1'b0;
    rd_en    = 1'b0;
    rd_ptr   = rp_q;

    if (ctl_i.cfg_wr) begin
      if (cfg_capacity_i < CapW'(MinRing)) begin
        ring_d = NW'(MinRing);
      end else if (32'(cfg_capacity_i) > DEPTH) begin
        ring_d = NW'(DEPTH);
      end else begin
        ring_d = NW'(cfg_capacity_i);
      end
      rp_d = '0;
      wp_d = '0;
    end

    if (ctl_i.exec) begin
      status_d = 1'b0;
      last_d   = 1'b1;
      sel_d    = 1'b0;
      rem_d    = '0;
      case (cmd_q)
        CmdPush: begin
          mem_we = 1'b1;
          if (full) begin
            rp_d = rp_nx;
          end
          wp_d = wp_nx;
        end
        CmdPop: begin
          if (empty) begin
            status_d = 1'b1;
          end else begin
            rd_en  = 1'b1;
            rd_ptr = rp_q;
            sel_d  = 1'b1;
            rp_d   = rp_nx;
          end
        end
        CmdPeek: begin
          if (7'(off_q) >= 7'(lv)) begin
            status_d = 1'b1;
          end else begin
            rd_en  = 1'b1;
            rd_ptr = p0;
            sel_d  = 1'b1;
            pk_d   = ring_next(p0, ring_q);
            rem_d  = KW'(num7 - 7'd1);
            last_d = (num7 == 7'd1);
          end
        end
        CmdDrop: begin
          if (!empty) begin
            rp_d = rp_nx;
          end
        end
        CmdClear: begin
          rp_d = '0;
          wp_d = '0;
        end
        default: begin
        end
      endcase
    end

    if (ctl_i.step) begin
      rd_en  = 1'b1;
      rd_ptr = pk_q;
      pk_d   = ring_next(pk_q, ring_q);
      rem_d  = rem_q - KW'(1);
      last_d = (rem_q == KW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[AW'(wp_q)] <= val_q;
    end
    if (rd_en) begin
      rd_q <= mem[AW'(rd_ptr)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= cmd_i;
      val_q <= push_value_i;
      off_q <= peek_offset_i;
      cnt_q <= peek_count_i;
    end
    pk_q <= pk_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q     <= '0;
      wp_q     <= '0;
      ring_q   <= RingRst;
      rem_q    <= '0;
      status_q <= 1'b0;
      last_q   <= 1'b0;
      sel_q    <= 1'b0;
    end else begin
      rp_q     <= rp_d;
      wp_q     <= wp_d;
      ring_q   <= ring_d;
      rem_q    <= rem_d;
      status_q <= status_d;
      last_q   <= last_d;
      sel_q    <= sel_d;
    end
  end

  assign sts_o.more  = (rem_q != '0);
  assign status_o    = status_q;
  assign last_o      = last_q;
  assign data_o      = sel_q ? rd_q : '0;
  assign level_o     = LevelW'(lv);
  assign is_empty_o  = empty;
  assign is_full_o   = full;

endmodule

[rtl/overwrite_ring_event_log.sv]
// Top level of the overwrite-oldest circular event log.
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------------
//  in      | in_valid_i/in_ready_o  | cmd_i push_value_i peek_offset_i peek_count_i
//  out     | out_valid_o/out_ready_i| status_o data_o last_o level_o is_empty_o
//          |                        | is_full_o
//  cfg     | cfg_valid_i/cfg_ready_o| cfg_capacity_i
//
// One request at a time: accept, execute, then the result is offered. A peek of N
// entries gives N results, one per cycle from the entry memory read port while
// out_ready_i stays high. Reset clears the read and write pointers and sets capacity
// to the smaller of DEPTH and 64; entries are not cleared. A stalled result holds
// until taken; no request is accepted meanwhile.
module overwrite_ring_event_log #(
  parameter int DEPTH    = 64,
  parameter int MAX_PEEK = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [owrl_pkg::CmdW-1:0]    cmd_i,
  input  logic [owrl_pkg::ValW-1:0]    push_value_i,
  input  logic [owrl_pkg::OffW-1:0]    peek_offset_i,
  input  logic [owrl_pkg::CntW-1:0]    peek_count_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         status_o,
  output logic [owrl_pkg::ValW-1:0]    data_o,
  output logic                         last_o,
  output logic [owrl_pkg::LevelW-1:0]  level_o,
  output logic                         is_empty_o,
  output logic                         is_full_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [owrl_pkg::CapW-1:0]    cfg_capacity_i
);
  import owrl_pkg::*;

  ctl_t ctl;
  sts_t sts;

  owrl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  owrl_dp #(
    .DEPTH    (DEPTH),
    .MAX_PEEK (MAX_PEEK)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .cfg_capacity_i (cfg_capacity_i),
    .cmd_i          (cmd_i),
    .push_value_i   (push_value_i),
    .peek_offset_i  (peek_offset_i),
    .peek_count_i   (peek_count_i),
    .status_o       (status_o),
    .data_o         (data_o),
    .last_o         (last_o),
    .level_o        (level_o),
    .is_empty_o     (is_empty_o),
    .is_full_o      (is_full_o)
  );

endmodule
